FILE: hw/rtl/ipmac_pkg.sv
// ----------------------------------------------------------------------------
// ipmac_pkg
// Types and codes shared by the IPv4-to-MAC exact-match table.
// ----------------------------------------------------------------------------
package ipmac_pkg;

    typedef enum logic [1:0]
    {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_MOD  = 2'd2,
        MODE_LOOK = 2'd3
    } mode_t;

    typedef struct packed
    {
        mode_t       mode;
        logic [31:0] ip_key;
        logic [31:0] new_ip_key;
        logic [47:0] mac_in;
    } req_t;

    typedef struct packed
    {
        logic        ok;
        logic [47:0] mac_out;
    } rsp_t;

    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_COMMIT = 2'd3
    } state_t;

    // controller to datapath
    typedef struct packed
    {
        logic load;
        logic scan_en;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic scan_last;
    } dp_status_t;

endpackage

FILE: hw/rtl/ipmac_ctrl.sv
// ----------------------------------------------------------------------------
// ipmac_ctrl
// Sequencer: accepts an item, steps the table scan, commits and hands off
// the result to the output register.
// ----------------------------------------------------------------------------
module ipmac_ctrl
    import ipmac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall   = 1'b1;
        cmd.load    = 1'b0;
        cmd.scan_en = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.scan_en = 1'b0;
            end
            ST_COMMIT:
            begin
                // wait until the previous result has been taken
                cmd.commit = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: hw/rtl/ipmac_dp.sv
// ----------------------------------------------------------------------------
// ipmac_dp
// Datapath: item register, key/MAC memories, valid bits, scan compare and
// the commit logic that updates the table and builds the result.
// ----------------------------------------------------------------------------
module ipmac_dp
    import ipmac_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output rsp_t       rsp
);

    req_t               item_reg;
    rsp_t               rsp_reg;
    logic [IDX_W-1:0]   cnt_reg;

    logic [31:0]        mem_ip  [TABLE_ENTRIES];
    logic [47:0]        mem_mac [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [31:0]        rd_ip_reg;
    logic [47:0]        rd_mac_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_vld_reg;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [47:0]        hit_mac_reg;
    logic               nhit_reg;
    logic [IDX_W-1:0]   nhit_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic               ent_vld;
    logic               key_match;
    logic               nkey_match;

    logic               res_ok;
    logic [47:0]        res_mac;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [31:0]        wr_ip;
    logic               set_vld;
    logic               clr_vld;

    assign status.scan_last = (cnt_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan_en;
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_en)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
        end
    end

    // one entry read per cycle, write only at commit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ip[wr_addr]  <= wr_ip;
            mem_mac[wr_addr] <= item_reg.mac_in;
        end
        if (cmd.scan_en)
        begin
            rd_ip_reg   <= mem_ip[cnt_reg];
            rd_mac_reg  <= mem_mac[cnt_reg];
            cmp_idx_reg <= cnt_reg;
        end
    end

    assign ent_vld    = valid_reg[cmp_idx_reg];
    assign key_match  = cmp_vld_reg && ent_vld && (rd_ip_reg == item_reg.ip_key);
    assign nkey_match = cmp_vld_reg && ent_vld && (rd_ip_reg == item_reg.new_ip_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            nhit_reg <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            nhit_reg <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            if (key_match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (nkey_match && !nhit_reg)
            begin
                nhit_reg <= 1'b1;
            end
            // lowest free slot wins
            if (cmp_vld_reg && !ent_vld && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_match && !hit_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_mac_reg <= rd_mac_reg;
        end
        if (nkey_match && !nhit_reg)
        begin
            nhit_idx_reg <= cmp_idx_reg;
        end
        if (cmp_vld_reg && !ent_vld && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    always_comb
    begin
        res_ok  = 1'b0;
        res_mac = '0;
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_ip   = item_reg.ip_key;
        set_vld = 1'b0;
        clr_vld = 1'b0;
        case (item_reg.mode)
            MODE_ADD:
            begin
                res_ok  = !hit_reg && free_reg;
                wr_addr = free_idx_reg;
                wr_en   = res_ok;
                set_vld = res_ok;
            end
            MODE_DEL:
            begin
                res_ok  = hit_reg;
                clr_vld = hit_reg;
            end
            MODE_MOD:
            begin
                // new key may sit in the same slot as the old one
                res_ok = hit_reg && (!nhit_reg || (nhit_idx_reg == hit_idx_reg));
                wr_ip  = item_reg.new_ip_key;
                wr_en  = res_ok;
            end
            MODE_LOOK:
            begin
                res_ok  = hit_reg;
                res_mac = hit_reg ? hit_mac_reg : 48'd0;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
        wr_en   = wr_en && cmd.commit;
        set_vld = set_vld && cmd.commit;
        clr_vld = clr_vld && cmd.commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (set_vld)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (clr_vld)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.ok      <= res_ok;
            rsp_reg.mac_out <= res_mac;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: hw/rtl/ipv4_to_mac_table_top.sv
// ----------------------------------------------------------------------------
// ipv4_to_mac_table_top
// Exact-match table mapping IPv4 keys to MAC addresses.
// ----------------------------------------------------------------------------
// Each request item carries one operation (add, delete, modify, lookup) and
// yields exactly one response item. The table keeps TABLE_ENTRIES slots in a
// key memory and a MAC memory with one read port each, plus a valid bit per
// slot held in flops and cleared by reset, so the table is empty right after
// reset with no clearing pass. Every item walks all slots through the single
// read port, one slot per cycle, then commits its update; the next item is
// taken only after that commit. The response sits in an output register, so
// the next request is taken while the previous response still waits on
// rsp_stall; the commit of that next item holds until the response register
// is free. Add uses the lowest free slot; modify may keep the same key.
module ipv4_to_mac_table_top
    import ipmac_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ipmac_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    ipmac_dp
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

FILE: verif/tb_ipv4_to_mac_table_top.sv
// ----------------------------------------------------------------------------
// tb_ipv4_to_mac_table_top
// Self-checking bench for the IPv4-to-MAC exact-match table.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the table. Each accepted request updates
// that copy and queues the response the block should give, and each accepted
// response is checked field by field against the oldest one queued. A short
// directed run covers the corner keys and the failing cases. A filling run
// then drives the table to full, and random phases follow that lean toward
// adds, toward deletes, modifies and lookups, or a mix. Both sides insert
// random gaps, and some phases run with no gaps at all.
module tb_ipv4_to_mac_table_top
    import ipmac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4 * (ENTRIES + 3);
    localparam int RANDOM_ITEMS = 500;

    class mac_table_scoreboard;
        bit          slot_used [ENTRIES];
        logic [31:0] slot_ip   [ENTRIES];
        logic [47:0] slot_mac  [ENTRIES];
        rsp_t        expected_rsp [$];
        int          errors;

        function int find_key(logic [31:0] key);
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_used[i] && slot_ip[i] == key)
                    return i;
            end
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!slot_used[i])
                    return i;
            end
            return -1;
        endfunction

        // apply one request to the table copy and queue its response
        function void note_request(req_t item);
            rsp_t want;
            int   hit;
            int   other;
            want = '0;
            hit  = find_key(item.ip_key);
            case (item.mode)
                MODE_ADD:
                begin
                    other = free_slot();
                    if (hit < 0 && other >= 0)
                    begin
                        slot_used[other] = 1'b1;
                        slot_ip[other]   = item.ip_key;
                        slot_mac[other]  = item.mac_in;
                        want.ok          = 1'b1;
                    end
                end
                MODE_DEL:
                begin
                    if (hit >= 0)
                    begin
                        slot_used[hit] = 1'b0;
                        want.ok        = 1'b1;
                    end
                end
                MODE_MOD:
                begin
                    if (hit >= 0)
                    begin
                        other = find_key(item.new_ip_key);
                        // same key is allowed, a key held elsewhere is not
                        if (other < 0 || other == hit)
                        begin
                            slot_ip[hit]  = item.new_ip_key;
                            slot_mac[hit] = item.mac_in;
                            want.ok       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (hit >= 0)
                    begin
                        want.ok      = 1'b1;
                        want.mac_out = slot_mac[hit];
                    end
                end
            endcase
            expected_rsp.push_back(want);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("response with none outstanding: ok %0d mac_out %h",
                       got.ok, got.mac_out);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                errors++;
            end
            if (got.mac_out !== want.mac_out)
            begin
                $error("mac_out: expected %h, actual %h", want.mac_out, got.mac_out);
                errors++;
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    bit calm = 1'b0;
    int idle_cycles = 0;
    mac_table_scoreboard sb = new();

    ipv4_to_mac_table_top #(
        .TABLE_ENTRIES (ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_op(input mode_t op, input logic [31:0] key,
                           input logic [31:0] new_key, input logic [47:0] mac);
        req_t item;
        int   gap;
        item = '{mode: op, ip_key: key, new_ip_key: new_key, mac_in: mac};
        gap  = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!(req_valid && !req_stall))
            @(posedge clk);
        sb.note_request(item);
    endtask

    // a key held in the table with the given chance, otherwise a fresh one
    function automatic logic [31:0] pick_key(int held_pct);
        int held [$];
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sb.slot_used[i])
                held.push_back(i);
        end
        if (held.size() > 0 && $urandom_range(0, 99) < held_pct)
            return sb.slot_ip[held[$urandom_range(0, held.size() - 1)]];
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int add_pct);
        mode_t       op;
        logic [31:0] key;
        logic [31:0] new_key;
        logic [47:0] mac;
        if ($urandom_range(0, 99) < add_pct)
            op = MODE_ADD;
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = MODE_DEL;
                1:       op = MODE_MOD;
                default: op = MODE_LOOK;
            endcase
        end
        key = pick_key(op == MODE_ADD ? 25 : 80);
        case ($urandom_range(0, 4))
            0:       new_key = key;
            1, 2:    new_key = pick_key(100);
            default: new_key = pick_key(0);
        endcase
        mac = 48'({$urandom, $urandom});
        send_op(op, key, new_key, mac);
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // response side: stall for a random count once a response shows up
    initial
    begin
        int hold;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                @(posedge clk);
                while (!rsp_valid)
                    @(posedge clk);
                repeat (hold - 1) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!(rsp_valid && !rsp_stall))
                @(posedge clk);
            sb.check_response(rsp);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL ipv4_to_mac_table_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int done;
        int phase_len;
        int add_pct;
        done = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every operation misses or fails
        send_op(MODE_LOOK, 32'h0000_0000, 32'h0000_0000, 48'h0);
        send_op(MODE_DEL,  32'hFFFF_FFFF, 32'h0000_0000, 48'h0);
        send_op(MODE_MOD,  32'h0000_0000, 32'h0000_0005, 48'h1234_5678_9ABC);
        // corner keys and macs
        send_op(MODE_ADD,  32'h0000_0000, 32'hFFFF_FFFF, 48'h0000_0000_0000);
        send_op(MODE_ADD,  32'hFFFF_FFFF, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_op(MODE_ADD,  32'h0000_0000, 32'h0000_0000, 48'h0000_0012_3456);
        send_op(MODE_LOOK, 32'h0000_0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_op(MODE_LOOK, 32'hFFFF_FFFF, 32'h0000_0000, 48'h0);
        // modify onto a key held by the other slot
        send_op(MODE_MOD,  32'hFFFF_FFFF, 32'h0000_0000, 48'h1111_1111_1111);
        // modify keeping the same key rewrites the mac
        send_op(MODE_MOD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h5555_5555_5555);
        send_op(MODE_LOOK, 32'hFFFF_FFFF, 32'h0000_0000, 48'h0);
        send_op(MODE_MOD,  32'h0000_0000, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
        send_op(MODE_LOOK, 32'h0000_0000, 32'h0000_0000, 48'h0);
        send_op(MODE_LOOK, 32'hAAAA_AAAA, 32'h0000_0000, 48'h0);
        send_op(MODE_DEL,  32'h0000_0000, 32'h0000_0000, 48'h0);
        send_op(MODE_DEL,  32'hAAAA_AAAA, 32'h5555_5555, 48'h0);
        send_op(MODE_LOOK, 32'hAAAA_AAAA, 32'h0000_0000, 48'h0);
        send_op(MODE_ADD,  32'h5555_5555, 32'hAAAA_AAAA, 48'h0000_FFFF_0000);
        send_op(MODE_LOOK, 32'h5555_5555, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        pause_until_drained();

        // fill the table, then push a few adds into the full table
        while (sb.free_slot() >= 0)
        begin
            send_random(100);
            done++;
        end
        repeat (3)
        begin
            send_random(100);
            done++;
        end

        add_pct = 10;
        while (done < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(30, 70);
            calm      = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len && done < RANDOM_ITEMS; n++)
            begin
                send_random(add_pct);
                done++;
            end
            calm = 1'b0;
            if ($urandom_range(0, 2) == 0)
                pause_until_drained();
            case ($urandom_range(0, 2))
                0:       add_pct = 85;
                1:       add_pct = 10;
                default: add_pct = 40;
            endcase
        end
        req_valid <= 1'b0;

        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS ipv4_to_mac_table_top");
        else
            $display("FAIL ipv4_to_mac_table_top");
        $finish;
    end

endmodule
